[src/pgf_pkg.sv]
// Shared widths, constants, register indexes, types and the sine table builder.
package pgf_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int POS_W    = 24;
    localparam int CNT_W    = 24;
    localparam int PHASE_W  = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Playback and tone constants
    localparam int SAMPLE_RATE        = 16000;
    localparam int FADE_SAMPLES       = 320;
    localparam int SINE_TABLE_ENTRIES = 1024;
    localparam int QUARTER_LEN        = SINE_TABLE_ENTRIES / 4;
    localparam int TONE_PEAK          = 6000;
    localparam int S_PEAK             = 32767;

    localparam logic [POS_W-1:0]   TOTAL_RESET = POS_W'(32000);
    localparam logic [PHASE_W-1:0] FREQ_RESET  = PHASE_W'(1000);

    localparam int IDX_W  = $clog2(SINE_TABLE_ENTRIES);
    localparam int OFF_W  = $clog2(QUARTER_LEN);
    localparam int MAG_W  = 15;
    localparam int RAMP_W = $clog2(FADE_SAMPLES + 1);

    // Angle index = floor(phase * ENTRIES / RATE), done as a reciprocal multiply.
    // The shift is large enough that the rounding error never crosses an integer.
    localparam int IDX_SHIFT = 21;
    localparam longint IDX_MULT_L =
        ((longint'(SINE_TABLE_ENTRIES) << IDX_SHIFT) + longint'(SAMPLE_RATE) - 1)
        / longint'(SAMPLE_RATE);
    localparam int IDX_MULT_W = 18;
    localparam logic [IDX_MULT_W-1:0] IDX_MULT = IDX_MULT_W'(IDX_MULT_L);

    // Tone magnitude = PEAK * ramp * s / (FADE * 32768) = (75 * ramp * s) >> 17,
    // since 4 * TONE_PEAK is a whole multiple of FADE_SAMPLES.
    localparam int TONE_SCALE_NUM   = TONE_PEAK * 4 / FADE_SAMPLES;
    localparam int TONE_SCALE_SHIFT = 17;

    // Serial multiplier: radix-4 digits over the ramp term
    localparam int K_W         = 16;
    localparam int MULT_DIGITS = K_W / 2;
    localparam int ACC_W       = MAG_W + 1;
    localparam int PROD_SHIFT  = TONE_SCALE_SHIFT - 2 * MULT_DIGITS;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_USE_PCM   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOOST_X8  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FREQUENCY = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CALC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             load;
        logic [MAG_W-1:0] mcand;
        logic [K_W-1:0]   mplier;
    } mul_req_t;

    typedef logic [SAMPLE_W-1:0] sine_rom_t [QUARTER_LEN];

    // Quarter-wave table in Q1.15, from a Q30 Taylor series rounded to nearest.
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t   rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] prod;
        longint      sum;
        for (int k = 0; k < QUARTER_LEN; k++)
        begin
            x    = (64'd2 * 64'd3373259426 * 64'(k)) / 64'(SINE_TABLE_ENTRIES);
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 7; n++)
            begin
                prod = (term * x2) >> 30;
                case (n)
                    1:       term = prod / 64'd6;
                    2:       term = prod / 64'd20;
                    3:       term = prod / 64'd42;
                    4:       term = prod / 64'd72;
                    5:       term = prod / 64'd110;
                    6:       term = prod / 64'd156;
                    default: term = prod / 64'd210;
                endcase
                if ((n % 2) == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            if (sum > (longint'(1) << 30))
                sum = longint'(1) << 30;
            rom[k] = SAMPLE_W'((64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30);
        end
        return rom;
    endfunction

endpackage

[src/pgf_sine_rom.sv]
// Quarter-wave sine lookup with mirroring into a full-wave magnitude and sign.
module pgf_sine_rom (
    input  logic [pgf_pkg::IDX_W-1:0] idx,
    output logic [pgf_pkg::MAG_W-1:0] mag,
    output logic                      neg
);

    localparam pgf_pkg::sine_rom_t ROM = pgf_pkg::build_sine_rom();

    logic [1:0]                quad;
    logic [pgf_pkg::OFF_W-1:0] off;
    logic [pgf_pkg::OFF_W-1:0] mir_off;

    always_comb
    begin
        quad    = idx[pgf_pkg::IDX_W-1 -: 2];
        off     = idx[pgf_pkg::OFF_W-1:0];
        mir_off = ~off + pgf_pkg::OFF_W'(1);
        if (quad[0])
        begin
            // The falling quarter reads the table backwards; its first entry is the peak.
            if (off == '0)
                mag = pgf_pkg::MAG_W'(pgf_pkg::S_PEAK);
            else
                mag = ROM[mir_off][pgf_pkg::MAG_W-1:0];
        end
        else
        begin
            mag = ROM[off][pgf_pkg::MAG_W-1:0];
        end
        neg = quad[1];
    end

endmodule

[src/pgf_serial_mult.sv]
// Radix-4 digit-serial multiplier that keeps only the high part of the product.
module pgf_serial_mult (
    input  logic                      clk,
    input  logic                      rst_n,
    input  pgf_pkg::mul_req_t         req,
    output logic                      done,
    output logic [pgf_pkg::ACC_W-1:0] prod_hi
);

    localparam int STEP_W = $clog2(pgf_pkg::MULT_DIGITS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(pgf_pkg::MULT_DIGITS - 1);

    logic                        busy_reg;
    logic                        done_reg;
    logic [STEP_W-1:0]           step_reg;
    logic [pgf_pkg::MAG_W-1:0]   mcand_reg;
    logic [pgf_pkg::MAG_W+1:0]   mcand3_reg;
    logic [pgf_pkg::K_W-1:0]     mplier_reg;
    logic [pgf_pkg::ACC_W-1:0]   acc_reg;
    logic [pgf_pkg::MAG_W+1:0]   addend;
    logic [pgf_pkg::ACC_W+1:0]   sum;

    always_comb
    begin
        case (mplier_reg[1:0])
            2'd0:    addend = '0;
            2'd1:    addend = {2'b00, mcand_reg};
            2'd2:    addend = {1'b0, mcand_reg, 1'b0};
            default: addend = mcand3_reg;
        endcase
        sum = {2'b00, acc_reg} + (pgf_pkg::ACC_W + 2)'(addend);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == LAST_STEP);
            if (req.load)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP)
                    busy_reg <= 1'b0;
            end
        end
    end

    // Least significant digit first: each step adds one partial product and
    // drops two bits, so only the high part of the product is ever held.
    always_ff @(posedge clk)
    begin
        if (req.load)
        begin
            mcand_reg  <= req.mcand;
            mcand3_reg <= {2'b00, req.mcand} + {1'b0, req.mcand, 1'b0};
            mplier_reg <= req.mplier;
            acc_reg    <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg    <= sum[pgf_pkg::ACC_W+1:2];
            mplier_reg <= mplier_reg >> 2;
        end
    end

    assign done    = done_reg;
    assign prod_hi = acc_reg;

endmodule

[src/pcm_gain_and_fade_tone_source_unit.sv]
// Top level: playback counters, PCM gain with saturation, faded tone and output register.
// A PCM item goes from acceptance to the output register through the done state; a tone item
// takes these steps: table read, 8 radix-4 steps of the serial multiplier, done flag, result.
// Input is taken again the cycle after an item reaches the output register, and the output
// register is loaded only while it is free, so one item is worked on at a time.
// rst_n clears position, phase and clip count and loads the register reset values;
// the sine table is constant and needs no clearing.
module pcm_gain_and_fade_tone_source_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] pcm_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [15:0] sample_out, [39:16] clip_count
    output logic        m_tuser,   // [0] clipped
    output logic        m_tlast
);

    localparam int SW = pgf_pkg::SAMPLE_W;
    localparam int PW = pgf_pkg::POS_W;
    localparam int CW = pgf_pkg::CNT_W;
    localparam int FW = pgf_pkg::PHASE_W;
    localparam int RW = pgf_pkg::RAMP_W;
    localparam logic [PW-1:0] FADE_POS  = PW'(pgf_pkg::FADE_SAMPLES);
    localparam logic [FW:0]   RATE_WIDE = (FW + 1)'(pgf_pkg::SAMPLE_RATE);
    localparam int IDX_PROD_W = FW + pgf_pkg::IDX_MULT_W;

    // Configuration
    logic          use_pcm_reg;
    logic          boost_reg;
    logic [PW-1:0] total_reg;
    logic [FW-1:0] freq_reg;

    // Playback state
    logic [PW-1:0] position_reg;
    logic [FW-1:0] phase_reg;
    logic [CW-1:0] clip_total_reg;

    pgf_pkg::state_t state_reg;
    pgf_pkg::state_t state_next;

    // Item held while the tone is worked out
    logic                      mode_pcm_reg;
    logic [SW-1:0]             pcm_val_reg;
    logic                      clip_reg;
    logic [CW-1:0]             count_reg;
    logic                      last_reg;
    logic [pgf_pkg::IDX_W-1:0] idx_reg;
    logic [RW-1:0]             ramp_reg;
    logic                      neg_reg;

    logic          m_tvalid_reg;
    logic [SW-1:0] out_sample_reg;
    logic [CW-1:0] out_count_reg;
    logic          out_clip_reg;
    logic          out_last_reg;

    logic accept;
    logic out_free;
    logic out_load;

    logic                       is_last;
    logic [PW-1:0]              remaining;
    logic [RW-1:0]              ramp;
    logic [IDX_PROD_W-1:0]      idx_prod;
    logic [FW:0]                phase_sum;
    logic [FW:0]                phase_red;
    logic [FW:0]                phase_mod;
    logic                       pcm_clip;
    logic [SW-1:0]              pcm_val;
    logic [CW-1:0]              count_inc;

    logic [pgf_pkg::MAG_W-1:0]  rom_mag;
    logic                       rom_neg;
    pgf_pkg::mul_req_t          mul_req;
    logic                       mul_done;
    logic [pgf_pkg::ACC_W-1:0]  mul_prod;
    logic [pgf_pkg::MAG_W-1:0]  tone_mag;
    logic [SW-1:0]              tone_sample;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_pcm_reg <= 1'b0;
            boost_reg   <= 1'b0;
            total_reg   <= pgf_pkg::TOTAL_RESET;
            freq_reg    <= pgf_pkg::FREQ_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pgf_pkg::REG_USE_PCM:   use_pcm_reg <= cfg_data[0];
                pgf_pkg::REG_BOOST_X8:  boost_reg   <= cfg_data[0];
                pgf_pkg::REG_TOTAL:     total_reg   <= cfg_data[PW-1:0];
                pgf_pkg::REG_FREQUENCY: freq_reg    <= cfg_data[FW-1:0];
                default:                use_pcm_reg <= use_pcm_reg;
            endcase
        end
    end

    // Per-item arithmetic on the playback state
    always_comb
    begin
        is_last   = ({1'b0, position_reg} + (PW + 1)'(1)) >= {1'b0, total_reg};
        remaining = (total_reg > position_reg) ? (total_reg - position_reg) : '0;
        if (position_reg < FADE_POS)
            ramp = position_reg[RW-1:0];
        else if (remaining < FADE_POS)
            ramp = remaining[RW-1:0];
        else
            ramp = RW'(pgf_pkg::FADE_SAMPLES);

        idx_prod = IDX_PROD_W'(phase_reg) * IDX_PROD_W'(pgf_pkg::IDX_MULT);

        // The step may be up to the full 14-bit range, so two corrections can be needed.
        phase_sum = {1'b0, phase_reg} + {1'b0, freq_reg};
        phase_red = (phase_sum >= RATE_WIDE) ? (phase_sum - RATE_WIDE) : phase_sum;
        phase_mod = (phase_red >= RATE_WIDE) ? (phase_red - RATE_WIDE) : phase_red;

        // Times eight overflows unless the top four bits all match the sign.
        pcm_clip = boost_reg && !((s_tdata[15:12] == 4'b0000) || (s_tdata[15:12] == 4'b1111));
        if (!boost_reg)
            pcm_val = s_tdata;
        else if (pcm_clip)
            pcm_val = s_tdata[15] ? 16'h8000 : 16'h7FFF;
        else
            pcm_val = {s_tdata[12:0], 3'b000};

        if (use_pcm_reg && pcm_clip && (clip_total_reg != {CW{1'b1}}))
            count_inc = clip_total_reg + CW'(1);
        else
            count_inc = clip_total_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg   <= '0;
            phase_reg      <= '0;
            clip_total_reg <= '0;
        end
        else if (accept)
        begin
            if (is_last)
            begin
                position_reg   <= '0;
                phase_reg      <= '0;
                clip_total_reg <= '0;
            end
            else
            begin
                position_reg   <= position_reg + PW'(1);
                phase_reg      <= phase_mod[FW-1:0];
                clip_total_reg <= count_inc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_pcm_reg <= use_pcm_reg;
            pcm_val_reg  <= pcm_val;
            clip_reg     <= use_pcm_reg && pcm_clip;
            count_reg    <= count_inc;
            last_reg     <= is_last;
            idx_reg      <= idx_prod[pgf_pkg::IDX_SHIFT +: pgf_pkg::IDX_W];
            ramp_reg     <= ramp;
        end
        if (state_reg == pgf_pkg::ST_LOAD)
            neg_reg <= rom_neg;
    end

    pgf_sine_rom u_rom (
        .idx (idx_reg),
        .mag (rom_mag),
        .neg (rom_neg)
    );

    always_comb
    begin
        mul_req.load   = (state_reg == pgf_pkg::ST_LOAD);
        mul_req.mcand  = rom_mag;
        mul_req.mplier = pgf_pkg::K_W'(ramp_reg) * pgf_pkg::K_W'(pgf_pkg::TONE_SCALE_NUM);
    end

    pgf_serial_mult u_mult (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .done    (mul_done),
        .prod_hi (mul_prod)
    );

    always_comb
    begin
        tone_mag    = pgf_pkg::MAG_W'(mul_prod >> pgf_pkg::PROD_SHIFT);
        tone_sample = neg_reg ? (SW'(0) - SW'(tone_mag)) : SW'(tone_mag);
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pgf_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = use_pcm_reg ? pgf_pkg::ST_DONE : pgf_pkg::ST_LOAD;
            end
            pgf_pkg::ST_LOAD:
                state_next = pgf_pkg::ST_CALC;
            pgf_pkg::ST_CALC:
            begin
                if (mul_done)
                    state_next = pgf_pkg::ST_DONE;
            end
            pgf_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = pgf_pkg::ST_IDLE;
            end
            default:
                state_next = pgf_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            pgf_pkg::ST_IDLE: s_tready = 1'b1;
            pgf_pkg::ST_DONE: out_load = out_free;
            default:
            begin
                s_tready = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= pgf_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_sample_reg <= mode_pcm_reg ? pcm_val_reg : tone_sample;
            out_count_reg  <= count_reg;
            out_clip_reg   <= clip_reg;
            out_last_reg   <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_count_reg, out_sample_reg};
    assign m_tuser  = out_clip_reg;
    assign m_tlast  = out_last_reg;

endmodule
